// ===== design/b64d_pkg.sv =====
// Shared types and constants for the dual-alphabet base64 decoder.
// No dependencies; every other design file refers to this package by scoped names.
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] BAD_SEXTET = 8'h80;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_byte;
  } out_item_t;

  // One decoded group as handed from the front end to the byte serialiser.
  typedef struct packed {
    logic [23:0] acc;       // group bits, byte 0 in [23:16]
    logic [1:0]  last_idx;  // index of the final byte to emit (0..2)
    logic        last;      // group closes the text
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Standard and URL-safe alphabets folded into one table.
  function automatic logic [7:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    v = BAD_SEXTET;
    if (c >= 8'h41 && c <= 8'h5A) v = c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A) v = c - 8'h61 + 8'd26;
    else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30 + 8'd52;
    else if (c == 8'h2B || c == 8'h2D) v = 8'd62;
    else if (c == 8'h2F || c == 8'h5F) v = 8'd63;
    return v;
  endfunction

endpackage

// ===== design/b64d_front.sv =====
// Front end: takes one character a cycle unless the queue is full, looks up its
// sextet, builds groups and pushes them into the queue. Depends on b64d_pkg.
module b64d_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  b64d_pkg::in_item_t   in_data,
  input  b64d_pkg::queue_stat_t q_stat,
  output logic                 push,
  output b64d_pkg::group_t     push_data
);

  logic [1:0]  pos_r, pos_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic        tpad_r, tpad_nxt;

  logic        accept;
  logic [7:0]  v;
  logic        is_pad;
  logic [23:0] base;
  logic [23:0] place;
  logic [23:0] acc_new;
  logic        tpad_eff;
  logic        second;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign v        = b64d_pkg::sextet_of(in_data.char_in);
  assign is_pad   = (in_data.char_in == b64d_pkg::PAD_CHAR);
  assign base     = (pos_r == 2'd0) ? 24'd0 : acc_r;

  // bits of the sextet that fall above bit 23 are dropped
  always_comb begin
    unique case (pos_r)
      2'd0: place = {v[5:0], 18'd0};
      2'd1: place = {4'd0, v, 12'd0};
      2'd2: place = {10'd0, v, 6'd0};
      2'd3: place = {16'd0, v};
    endcase
  end

  assign acc_new  = base | place;
  assign tpad_eff = (pos_r == 2'd2) ? is_pad : tpad_r;

  always_comb begin
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    tpad_nxt  = tpad_r;
    push      = 1'b0;
    push_data = '{acc: acc_new, last_idx: 2'd2, last: 1'b0};
    second    = 1'b0;
    if (accept) begin
      if (!in_data.end_of_text) begin
        if (pos_r == 2'd3) begin
          push     = 1'b1;
          pos_nxt  = 2'd0;
          acc_nxt  = 24'd0;
          tpad_nxt = 1'b0;
        end else begin
          pos_nxt  = pos_r + 2'd1;
          acc_nxt  = acc_new;
          tpad_nxt = tpad_eff;
        end
      end else begin
        push           = 1'b1;
        push_data.last = 1'b1;
        if (pos_r == 2'd3 && !is_pad) begin
          push_data.last_idx = 2'd2;
        end else begin
          if (pos_r == 2'd3) second = !tpad_r;
          else if (pos_r == 2'd2) second = !is_pad;
          push_data.last_idx = second ? 2'd1 : 2'd0;
        end
        pos_nxt  = 2'd0;
        acc_nxt  = 24'd0;
        tpad_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 2'd0;
      acc_r  <= 24'd0;
      tpad_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      acc_r  <= acc_nxt;
      tpad_r <= tpad_nxt;
    end
  end

endmodule

// ===== design/b64d_queue.sv =====
// Short group queue between front end and serialiser (register file FIFO).
// Depends on b64d_pkg for the group and status types.
module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  b64d_pkg::group_t      push_data,
  input  logic                  pop,
  output b64d_pkg::group_t      head,
  output b64d_pkg::queue_stat_t q_stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  b64d_pkg::group_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + CW'(1);
    else if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("group pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !pop)
    else $error("group popped from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.empty || q_stat.full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

// ===== design/b64d_back.sv =====
// Back end: serialises queued groups into bytes through a registered output.
// Depends on b64d_pkg.
module b64d_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  b64d_pkg::group_t      head,
  input  b64d_pkg::queue_stat_t q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output b64d_pkg::out_item_t   out_data
);

  logic [1:0]           idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  b64d_pkg::out_item_t  out_data_r, out_data_nxt;
  logic                 load;
  logic                 at_end;
  logic [7:0]           sel;

  assign load   = !q_stat.empty && (!out_valid_r || !out_stall);
  assign at_end = (idx_r == head.last_idx);
  assign pop    = load && at_end;

  always_comb begin
    unique case (idx_r)
      2'd0:    sel = head.acc[23:16];
      2'd1:    sel = head.acc[15:8];
      default: sel = head.acc[7:0];
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{byte_out: sel, last_byte: head.last && at_end};
      idx_nxt       = at_end ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/base64_dual_alphabet_decoder_top.sv =====
// Top level of the dual-alphabet base64 decoder.
// Instantiates b64d_front, b64d_queue and b64d_back; types from b64d_pkg.
//
// Usage
//   in_ channel : one encoded character per request, end_of_text set on the
//                 final character of a text. Both '+' '/' and '-' '_' decode.
//   out_ channel: one decoded byte per request, last_byte set on the final
//                 byte of each text (every text yields at least one byte).
//   A request moves on a rising edge where valid is high and stall is low.
// Throughput: one character a cycle in while the queue has room, one byte a
//   cycle out while out_stall is low. The front end classifies and packs each
//   character as it is taken; the serialiser emits one byte of a queued group
//   per cycle, so a full group of four characters yields three output bytes.
// Path: a group is written into the queue at the edge that takes its closing
//   character; its first byte then goes out through the output register.
// Stalling: out_stall holds the output register; the queue (QUEUE_DEPTH
//   groups) absorbs the front end until full, then in_stall rises. in_stall
//   is a register decode and never depends on out_stall in the same cycle.
// Reset: rst_n low clears group position, accumulator, queue and output
//   valid; the block is ready to take characters once rst_n is high.
module base64_dual_alphabet_decoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  b64d_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output b64d_pkg::out_item_t out_data
);

  // front to queue
  logic                  push;
  b64d_pkg::group_t      push_data;
  // queue to back
  logic                  pop;
  b64d_pkg::group_t      head;
  b64d_pkg::queue_stat_t q_stat;

  b64d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
